// File: rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on the next rising clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_CLK(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

// File: rtl/ptrt_pkg.sv
// types and codes of the periodic task release table
`timescale 1ns / 1ps
package ptrt_pkg;

  localparam int unsigned DVD_W = 32;
  localparam int unsigned PER_W = 16;

  localparam logic [2:0] MODE_TICK     = 3'd0;
  localparam logic [2:0] MODE_CREATE   = 3'd1;
  localparam logic [2:0] MODE_DELETE   = 3'd2;
  localparam logic [2:0] MODE_ACTIVATE = 3'd3;
  localparam logic [2:0] MODE_SUSPEND  = 3'd4;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_DUE    = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_REJ  = 2'd1;
  localparam logic [1:0] ST_NULL = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CHK  = 5'b00100,
    S_DIV  = 5'b01000,
    S_NEXT = 5'b10000
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [PER_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } mod_rsp_t;

endpackage

// File: rtl/ptrt_mod.sv
// bit-serial restoring remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps
module ptrt_mod
  import ptrt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);

  localparam int unsigned CW = $clog2(DVD_W);

  logic [DVD_W-1:0] dvd_q;
  logic [PER_W-1:0] div_q;
  logic [PER_W-1:0] rem_q;
  logic [CW-1:0]    cnt_q;
  logic             run_q;
  logic             done_q;

  logic [PER_W:0]   trial;
  logic             fits;
  logic [PER_W-1:0] rem_d;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, div_q};
  assign rem_d = fits ? PER_W'(trial - {1'b0, div_q}) : trial[PER_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(DVD_W - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      div_q <= req_i.divisor;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.rem_zero = (rem_q == '0);

endmodule

// File: rtl/periodic_task_release_table_unit.sv
// periodic task release table: slot table, tick counter and release walk
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  command  | start_i / busy_o      | mode_i, slot_i, period_i, handler_present_i
//  result   | valid_o (one cycle)   | kind_o, status_o, task_slot_o, last_o
//
// a create, delete, activate or suspend word gives its status word the next cycle,
// and a new word is taken in that same cycle
// a tick walks the slots one after another: a slot that is not due to be checked
// passes S_RD, S_CHK and S_NEXT, an active one with a nonzero period also waits
// in S_DIV on the 32-step shared remainder unit; busy_o is high throughout a tick
// reset clears the counter and the in-use and active flags; the receiver cannot stall
`timescale 1ns / 1ps
module periodic_task_release_table_unit
  import ptrt_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  slot_i,
  input  logic [15:0] period_i,
  input  logic        handler_present_i,
  output logic        valid_o,
  output logic [1:0]  kind_o,
  output logic [1:0]  status_o,
  output logic [7:0]  task_slot_o,
  output logic        last_o
);

  localparam int unsigned IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  state_e state_q, state_d;

  logic [DVD_W-1:0]      count_q;
  logic [TASK_SLOTS-1:0] used_q, used_d;
  logic [TASK_SLOTS-1:0] active_q, active_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [PER_W-1:0]      per_rd_q;
  logic [PER_W-1:0]      period_mem [TASK_SLOTS];

  logic       valid_q, valid_d;
  logic [1:0] kind_q, kind_d;
  logic [1:0] status_q, status_d;
  logic [7:0] task_slot_q, task_slot_d;
  logic       last_q, last_d;

  logic          accept;
  logic          in_range;
  logic [IW-1:0] sidx;
  logic          per_wr;
  logic [PER_W-1:0] per_wdata;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  assign accept   = start_i && !busy_o;
  assign in_range = {1'b0, slot_i} < 9'(TASK_SLOTS);
  assign sidx     = slot_i[IW-1:0];

  ptrt_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    active_d    = active_q;
    idx_d       = idx_q;
    valid_d     = 1'b0;
    kind_d      = KIND_STATUS;
    status_d    = ST_OK;
    task_slot_d = '0;
    last_d      = 1'b0;
    per_wr      = 1'b0;
    per_wdata   = period_i;
    mod_req.start    = 1'b0;
    mod_req.dividend = count_q;
    mod_req.divisor  = per_rd_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (mode_i == MODE_TICK) begin
            idx_d   = '0;
            state_d = S_RD;
          end else begin
            valid_d = 1'b1;
            last_d  = 1'b1;
            unique case (mode_i)
              MODE_CREATE: begin
                if (!handler_present_i) begin
                  status_d = ST_NULL;
                end else if (in_range && !used_q[sidx]) begin
                  used_d[sidx]   = 1'b1;
                  active_d[sidx] = 1'b0;
                  per_wr         = 1'b1;
                end else begin
                  status_d = ST_REJ;
                end
              end
              MODE_DELETE: begin
                if (in_range && used_q[sidx]) begin
                  used_d[sidx]   = 1'b0;
                  active_d[sidx] = 1'b0;
                  per_wr         = 1'b1;
                  per_wdata      = '0;
                end else begin
                  status_d = ST_REJ;
                end
              end
              MODE_ACTIVATE: begin
                if (in_range && used_q[sidx]) active_d[sidx] = 1'b1;
                else status_d = ST_REJ;
              end
              MODE_SUSPEND: begin
                if (in_range && used_q[sidx]) active_d[sidx] = 1'b0;
                else status_d = ST_REJ;
              end
              default: status_d = ST_REJ;
            endcase
          end
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (active_q[idx_q] && per_rd_q != '0) begin
          mod_req.start = 1'b1;
          state_d       = S_DIV;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_DIV: begin
        if (mod_rsp.done) begin
          if (mod_rsp.rem_zero) begin
            valid_d     = 1'b1;
            kind_d      = KIND_DUE;
            task_slot_d = 8'(idx_q);
          end
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (idx_q == IW'(TASK_SLOTS - 1)) begin
          valid_d = 1'b1;
          kind_d  = KIND_DONE;
          last_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      used_q      <= '0;
      active_q    <= '0;
      idx_q       <= '0;
      valid_q     <= 1'b0;
      kind_q      <= KIND_STATUS;
      status_q    <= ST_OK;
      task_slot_q <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      active_q    <= active_d;
      idx_q       <= idx_d;
      valid_q     <= valid_d;
      kind_q      <= kind_d;
      status_q    <= status_d;
      task_slot_q <= task_slot_d;
      last_q      <= last_d;
      if (accept && mode_i == MODE_TICK) count_q <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (per_wr) period_mem[sidx] <= per_wdata;
    if (state_q == S_RD) per_rd_q <= period_mem[idx_q];
  end

  assign busy_o      = (state_q != S_IDLE);
  assign valid_o     = valid_q;
  assign kind_o      = kind_q;
  assign status_o    = status_q;
  assign task_slot_o = task_slot_q;
  assign last_o      = last_q;

endmodule

// File: rtl/ptrt_checker.sv
// port-level checks for the periodic task release table
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ptrt_checker
  import ptrt_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [2:0] mode_i,
  input logic       valid_o,
  input logic [1:0] kind_o,
  input logic [1:0] status_o,
  input logic [7:0] task_slot_o,
  input logic       last_o
);

  `ASSERT_CLK(a_due_not_last, clk_i, rst_ni, (valid_o && kind_o == KIND_DUE) |-> (!last_o && status_o == ST_OK), "task due word marked last")
  `ASSERT_CLK(a_done_last, clk_i, rst_ni, (valid_o && kind_o == KIND_DONE) |-> (last_o && task_slot_o == 8'd0), "tick done word malformed")
  `ASSERT_NEXT(a_cmd_status, clk_i, rst_ni, start_i && !busy_o && mode_i != MODE_TICK, valid_o && kind_o == KIND_STATUS && last_o && !busy_o, "command gave no status word")
  `ASSERT_NEXT(a_tick_busy, clk_i, rst_ni, start_i && !busy_o && mode_i == MODE_TICK, busy_o && !valid_o, "tick did not start its walk")
  `ASSERT_CLK(a_idle_done, clk_i, rst_ni, (valid_o && kind_o == KIND_DUE) |-> busy_o, "task due word outside a tick")

endmodule

bind periodic_task_release_table_unit ptrt_checker u_ptrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .mode_i      (mode_i),
  .valid_o     (valid_o),
  .kind_o      (kind_o),
  .status_o    (status_o),
  .task_slot_o (task_slot_o),
  .last_o      (last_o)
);

// File: tb/tb_periodic_task_release_table_unit.sv
// self-checking testbench for the periodic task release table unit
`timescale 1ns / 1ps
module tb_periodic_task_release_table_unit;
  import ptrt_pkg::*;

  localparam int unsigned N_SLOTS    = 8;
  localparam int unsigned SW         = $clog2(N_SLOTS);
  localparam int unsigned WDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYC  = 400;
  localparam int unsigned N_RAND     = 145;
  localparam int unsigned N_PHASE    = 3;
  localparam int unsigned N_DIR      = 25;
  localparam int unsigned MAX_REPORT = 10;
  localparam logic [2:0]  MODE_UNK_LO = 3'd5;
  localparam logic [2:0]  MODE_UNK_HI = 3'd7;
  localparam int unsigned PHASE_IDLE [N_PHASE] = '{19, 65, 0};

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
    logic [7:0] task_slot;
    logic       last;
  } sched_word_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  slot;
    logic [15:0] period;
    logic        hp;
    logic        typed;
    logic [1:0]  st;
  } cmd_row_t;

  localparam cmd_row_t CMD_TAB [N_DIR] = '{
    '{MODE_TICK,     8'd0,   16'd0,     1'b1, 1'b0, ST_OK},
    '{MODE_CREATE,   8'd0,   16'd0,     1'b0, 1'b1, ST_NULL},
    '{MODE_CREATE,   8'hFF,  16'hFFFF,  1'b0, 1'b1, ST_NULL},
    '{MODE_CREATE,   8'hFF,  16'd1,     1'b1, 1'b1, ST_REJ},
    '{MODE_CREATE,   8'd8,   16'd1,     1'b1, 1'b1, ST_REJ},
    '{MODE_DELETE,   8'd0,   16'd0,     1'b1, 1'b1, ST_REJ},
    '{MODE_ACTIVATE, 8'd3,   16'd0,     1'b1, 1'b1, ST_REJ},
    '{MODE_SUSPEND,  8'd7,   16'd0,     1'b1, 1'b1, ST_REJ},
    '{MODE_CREATE,   8'd0,   16'd1,     1'b1, 1'b1, ST_OK},
    '{MODE_CREATE,   8'd0,   16'd5,     1'b1, 1'b1, ST_REJ},
    '{MODE_CREATE,   8'd7,   16'hFFFF,  1'b1, 1'b1, ST_OK},
    '{MODE_CREATE,   8'd3,   16'd0,     1'b1, 1'b1, ST_OK},
    '{MODE_ACTIVATE, 8'd0,   16'd0,     1'b1, 1'b1, ST_OK},
    '{MODE_ACTIVATE, 8'd7,   16'd0,     1'b1, 1'b1, ST_OK},
    '{MODE_ACTIVATE, 8'd3,   16'd0,     1'b1, 1'b1, ST_OK},
    '{MODE_CREATE,   8'd1,   16'd2,     1'b1, 1'b1, ST_OK},
    '{MODE_ACTIVATE, 8'd1,   16'd0,     1'b1, 1'b1, ST_OK},
    '{MODE_TICK,     8'd0,   16'd0,     1'b1, 1'b0, ST_OK},
    '{MODE_TICK,     8'd0,   16'd0,     1'b1, 1'b0, ST_OK},
    '{MODE_UNK_LO,   8'd0,   16'd0,     1'b1, 1'b1, ST_REJ},
    '{MODE_UNK_HI,   8'hFF,  16'hFFFF,  1'b0, 1'b1, ST_REJ},
    '{MODE_SUSPEND,  8'd0,   16'd0,     1'b1, 1'b1, ST_OK},
    '{MODE_TICK,     8'd0,   16'd0,     1'b1, 1'b0, ST_OK},
    '{MODE_DELETE,   8'd7,   16'd0,     1'b1, 1'b1, ST_OK},
    '{MODE_DELETE,   8'd7,   16'd0,     1'b1, 1'b1, ST_REJ}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [2:0]  mode_i;
  logic [7:0]  slot_i;
  logic [15:0] period_i;
  logic        handler_present_i;
  logic        valid_o;
  logic [1:0]  kind_o;
  logic [1:0]  status_o;
  logic [7:0]  task_slot_o;
  logic        last_o;

  logic [31:0] tick_cnt;
  logic        slot_used [N_SLOTS];
  logic [15:0] slot_per  [N_SLOTS];
  logic        slot_act  [N_SLOTS];
  sched_word_t sched_word_q [$];
  int unsigned err_cnt  = 0;
  int unsigned n_items  = 0;
  int unsigned n_ticks  = 0;
  int unsigned n_due    = 0;
  int unsigned n_rej    = 0;
  int unsigned idle_cyc = 0;

  periodic_task_release_table_unit #(
    .TASK_SLOTS(N_SLOTS)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .mode_i           (mode_i),
    .slot_i           (slot_i),
    .period_i         (period_i),
    .handler_present_i(handler_present_i),
    .valid_o          (valid_o),
    .kind_o           (kind_o),
    .status_o         (status_o),
    .task_slot_o      (task_slot_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void push_word(logic [1:0] kind, logic [1:0] st, logic [7:0] ts,
                                    logic last);
    sched_word_t w;
    w.kind      = kind;
    w.status    = st;
    w.task_slot = ts;
    w.last      = last;
    sched_word_q.push_back(w);
  endfunction

  function automatic void schedule_step(logic [2:0] mode, logic [7:0] slot,
                                        logic [15:0] per, logic hp, logic quiet);
    logic          in_rng;
    logic          used;
    logic [1:0]    st;
    logic [SW-1:0] si;
    in_rng = slot < N_SLOTS;
    si     = slot[SW-1:0];
    used   = 1'b0;
    if (in_rng) used = slot_used[si];
    st = ST_OK;
    case (mode)
      MODE_TICK: begin
        n_ticks++;
        tick_cnt = tick_cnt + 32'd1;
        for (int i = 0; i < N_SLOTS; i++) begin
          if (slot_act[SW'(i)] && slot_per[SW'(i)] != '0 &&
              (tick_cnt % {16'd0, slot_per[SW'(i)]}) == '0)
            push_word(KIND_DUE, ST_OK, 8'(i), 1'b0);
        end
        push_word(KIND_DONE, ST_OK, '0, 1'b1);
        return;
      end
      MODE_CREATE: begin
        if (!hp) begin
          st = ST_NULL;
        end else if (in_rng && !used) begin
          slot_used[si] = 1'b1;
          slot_per[si]  = per;
          slot_act[si]  = 1'b0;
        end else begin
          st = ST_REJ;
        end
      end
      MODE_DELETE: begin
        if (used) begin
          slot_used[si] = 1'b0;
          slot_per[si]  = '0;
          slot_act[si]  = 1'b0;
        end else begin
          st = ST_REJ;
        end
      end
      MODE_ACTIVATE: begin
        if (used) slot_act[si] = 1'b1;
        else st = ST_REJ;
      end
      MODE_SUSPEND: begin
        if (used) slot_act[si] = 1'b0;
        else st = ST_REJ;
      end
      default: st = ST_REJ;
    endcase
    if (!quiet) push_word(KIND_STATUS, st, '0, 1'b1);
  endfunction

  // mostly valid slots and short periods so that releases happen often
  function automatic cmd_row_t rand_cmd();
    cmd_row_t    c;
    int unsigned pick;
    c = '0;
    pick = $urandom_range(99);
    if (pick < 36) c.mode = MODE_TICK;
    else if (pick < 58) c.mode = MODE_CREATE;
    else if (pick < 70) c.mode = MODE_DELETE;
    else if (pick < 85) c.mode = MODE_ACTIVATE;
    else if (pick < 94) c.mode = MODE_SUSPEND;
    else c.mode = 3'($urandom_range(MODE_UNK_HI, MODE_UNK_LO));
    c.slot = ($urandom_range(99) < 85) ? 8'($urandom_range(N_SLOTS - 1)) : 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) c.period = 16'($urandom_range(4, 1));
    else if (pick < 70) c.period = 16'($urandom_range(12, 5));
    else if (pick < 80) c.period = '0;
    else c.period = 16'($urandom);
    c.hp = $urandom_range(99) < 92;
    return c;
  endfunction

  task automatic send_word(int unsigned idle_pct, cmd_row_t c);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i           <= 1'b1;
    mode_i            <= c.mode;
    slot_i            <= c.slot;
    period_i          <= c.period;
    handler_present_i <= c.hp;
    do @(posedge clk_i); while (busy_o);
    if (c.typed) push_word(KIND_STATUS, c.st, '0, 1'b1);
    schedule_step(c.mode, c.slot, c.period, c.hp, c.typed);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic drain_words();
    start_i <= 1'b0;
    do @(negedge clk_i); while (sched_word_q.size() != 0);
  endtask

  always @(posedge clk_i) begin
    sched_word_t got;
    sched_word_t want;
    if (rst_ni) begin
      if (valid_o || (start_i && !busy_o)) idle_cyc = 0;
      else idle_cyc++;
      if (valid_o) begin
        got.kind      = kind_o;
        got.status    = status_o;
        got.task_slot = task_slot_o;
        got.last      = last_o;
        if (got.kind == KIND_DUE) n_due++;
        if (got.kind == KIND_STATUS && got.status != ST_OK) n_rej++;
        if (sched_word_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORT)
            $display("unexpected word: kind %0d status %0d slot %0d last %0d",
                     got.kind, got.status, got.task_slot, got.last);
        end else begin
          want = sched_word_q.pop_front();
          if (got.kind !== want.kind || got.status !== want.status ||
              got.task_slot !== want.task_slot || got.last !== want.last) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORT)
              $display("mismatch: expected kind %0d status %0d slot %0d last %0d,",
                       want.kind, want.status, want.task_slot, want.last,
                       " got %0d %0d %0d %0d",
                       got.kind, got.status, got.task_slot, got.last);
          end
        end
      end
      if (idle_cyc >= WDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d words pending",
                 WDOG_LIMIT, sched_word_q.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    start_i           = 1'b0;
    mode_i            = MODE_TICK;
    slot_i            = '0;
    period_i          = '0;
    handler_present_i = 1'b0;
    tick_cnt          = '0;
    for (int i = 0; i < N_SLOTS; i++) begin
      slot_used[SW'(i)] = 1'b0;
      slot_per[SW'(i)]  = '0;
      slot_act[SW'(i)]  = 1'b0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < N_DIR; r++) send_word(PHASE_IDLE[0], CMD_TAB[r]);
    drain_words();

    for (int p = 0; p < N_PHASE; p++) begin
      for (int k = 0; k < N_RAND; k++) begin
        if (k == N_RAND / 2) drain_words();
        send_word(PHASE_IDLE[p], rand_cmd());
      end
    end
    drain_words();
    repeat (DRAIN_CYC) @(negedge clk_i);

    $display("run covered %0d command words: %0d ticks, %0d task releases,",
             n_items, n_ticks, n_due, " %0d refused statuses", n_rej);
    $display("sender idle settings of 19, 65 and 0 percent, %0d mismatches", err_cnt);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ptrt_pkg.sv
rtl/ptrt_mod.sv
rtl/periodic_task_release_table_unit.sv
rtl/ptrt_checker.sv
tb/tb_periodic_task_release_table_unit.sv
